@@ hw/rtl/cseu_pkg.sv @@
package cseu_pkg;

    localparam int X_W     = 32;
    localparam int IDX_W   = 4;
    localparam int SCALE_W = 31;
    localparam int TERM_W  = 5;
    localparam int B_W     = 48;
    localparam int ACC_W   = 52;
    localparam int TMAG_W  = 31;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    localparam logic KIND_EVAL = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    localparam logic [1:0] REG_DOMAIN_START = 2'd0;
    localparam logic [1:0] REG_DOMAIN_SCALE = 2'd1;
    localparam logic [1:0] REG_TERM_COUNT   = 2'd2;

    localparam logic signed [X_W-1:0]     RST_DOMAIN_START = 32'sd0;
    localparam logic        [SCALE_W-1:0] RST_DOMAIN_SCALE = 31'd65536;
    localparam logic        [TERM_W-1:0]  RST_TERM_COUNT   = 5'd2;

    // Upper clamp of scale*(x - start), i.e. t = +1.0 in Q32.32 after the offset.
    localparam logic signed [63:0] Q_CLAMP_HI = 64'sh0000_0002_0000_0000;
    // 1.0 in Q2.30.
    localparam logic signed [32:0] T_ONE = 33'sd1073741824;

    localparam logic signed [ACC_W-1:0] B_MAX   = 52'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] B_MIN   = 52'shF_8000_0000_0000;
    localparam logic signed [ACC_W-1:0] OUT_MAX = 52'sh0_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] OUT_MIN = 52'shF_FFFF_8000_0000;

    typedef struct packed {
        logic clear;
        logic mul;
        logic acc;
        logic last_term;
        logic empty;
    } step_ctl_t;

endpackage

@@ hw/rtl/cseu_cell.sv @@
module cseu_cell import cseu_pkg::*; (
    input  logic                  aclk,
    input  logic                  load_en,
    input  logic signed [X_W-1:0] load_word,
    input  logic                  shift_en,
    input  logic signed [X_W-1:0] shift_in,
    output logic signed [X_W-1:0] word_out
);

    logic signed [X_W-1:0] word_reg;
    logic signed [X_W-1:0] word_next;

    always_comb begin
        word_next = word_reg;
        if (load_en) begin
            word_next = load_word;
        end else if (shift_en) begin
            word_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word_out = word_reg;

endmodule

@@ hw/rtl/cseu_step.sv @@
module cseu_step import cseu_pkg::*; (
    input  logic                  aclk,
    input  step_ctl_t             ctl,
    input  logic                  t_neg,
    input  logic [TMAG_W-1:0]     t_mag,
    input  logic signed [X_W-1:0] coef,
    output logic signed [X_W-1:0] result,
    output logic                  saturated
);

    logic signed [B_W-1:0] b1_reg, b1_next;
    logic signed [B_W-1:0] b2_reg, b2_next;
    logic [62:0]           lo_prod_reg, lo_prod_next;
    logic [46:0]           hi_prod_reg, hi_prod_next;
    logic                  neg_reg, neg_next;
    logic signed [X_W-1:0] result_reg, result_next;
    logic                  sat_reg, sat_next;

    logic [B_W-1:0]          b1_mag;
    logic [50:0]             mag;
    logic signed [ACC_W-1:0] prod_s;
    logic signed [ACC_W-1:0] coef_ext;
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] b_sat;
    logic signed [ACC_W-1:0] out_sat;
    logic                    out_clip;

    always_comb begin
        b1_mag = b1_reg[B_W-1] ? (~b1_reg + 1'b1) : b1_reg;
        lo_prod_next = b1_mag[31:0] * t_mag;
        hi_prod_next = b1_mag[B_W-1:32] * t_mag;
        neg_next = b1_reg[B_W-1] ^ t_neg;

        // The final term uses t*b1, the others 2*t*b1.
        if (ctl.last_term) begin
            mag = (51'(hi_prod_reg) << 2) + 51'(lo_prod_reg >> 30);
        end else begin
            mag = (51'(hi_prod_reg) << 3) + 51'(lo_prod_reg >> 29);
        end
        prod_s = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        coef_ext = ACC_W'(coef);
        if (ctl.last_term) begin
            coef_ext = coef_ext <<< 1;
        end
        sum = coef_ext + prod_s - ACC_W'(b2_reg);

        if (sum > B_MAX) begin
            b_sat = B_MAX;
        end else if (sum < B_MIN) begin
            b_sat = B_MIN;
        end else begin
            b_sat = sum;
        end

        out_clip = 1'b1;
        if (sum > OUT_MAX) begin
            out_sat = OUT_MAX;
        end else if (sum < OUT_MIN) begin
            out_sat = OUT_MIN;
        end else begin
            out_sat = sum;
            out_clip = 1'b0;
        end

        b1_next = b1_reg;
        b2_next = b2_reg;
        result_next = result_reg;
        sat_next = sat_reg;
        if (ctl.clear) begin
            b1_next = '0;
            b2_next = '0;
        end else if (ctl.acc && !ctl.last_term) begin
            b2_next = b1_reg;
            b1_next = b_sat[B_W-1:0];
        end
        if (ctl.acc && ctl.last_term) begin
            if (ctl.empty) begin
                result_next = '0;
                sat_next = 1'b0;
            end else begin
                result_next = out_sat[X_W-1:0];
                sat_next = out_clip;
            end
        end
    end

    always_ff @(posedge aclk) begin
        b1_reg <= b1_next;
        b2_reg <= b2_next;
        result_reg <= result_next;
        sat_reg <= sat_next;
        if (ctl.mul) begin
            lo_prod_reg <= lo_prod_next;
            hi_prod_reg <= hi_prod_next;
            neg_reg <= neg_next;
        end
    end

    assign result = result_reg;
    assign saturated = sat_reg;

endmodule

@@ hw/rtl/chebyshev_series_evaluator_unit.sv @@
// Chebyshev series evaluator using the Clenshaw recurrence, Q16.16 in and out.
// Input channel (s_): s_tuser selects the transaction kind. A load transaction
// writes operand_value into coefficient slot coef_index and returns nothing.
// An evaluate transaction maps x onto t in [-1,1] and returns one result on
// the m_ channel: the series value, saturated, and a flag set when clipped.
// Configuration registers (domain start, domain scale, term count) are written
// through the cfg_ port; the user must write them only while no evaluation is in
// flight, which the block itself does not enforce. Coefficients live in a ring of
// MAX_TERMS cells, advanced one slot per slot visited, feeding one shared
// recurrence unit. A load writes its cell and leaves the block idle. An
// evaluation with n = min(term_count, MAX_TERMS) terms in use maps x to t
// (states MAP, TMAP), then walks the slots down from MAX_TERMS-1: each term in
// use takes a partial-product step, then an accumulate step, each unused slot
// only shifts the ring, and slot 0 always takes both (n zero gives a zero
// result). The next transaction is accepted in the cycle after the result
// is registered. A finished result waits in the output register while
// m_tready is low; the block stays busy until that register is free. Reset
// empties the output, returns to idle and restores the register defaults;
// coefficient slots hold no defined value until loaded.
module chebyshev_series_evaluator_unit import cseu_pkg::*; #(
    parameter int MAX_TERMS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // coef_index[3:0], operand_value[35:4], zero pad
    input  logic                s_tuser,   // kind[0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // series_value[31:0], saturated[32], zero pad
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [X_W-1:0]      cfg_wdata
);

    localparam int JW = $clog2(MAX_TERMS);
    localparam int NW = $clog2(MAX_TERMS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAP  = 3'd1;
    localparam logic [2:0] ST_TMAP = 3'd2;
    localparam logic [2:0] ST_RUN  = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]                 state_reg, state_next;
    logic signed [X_W-1:0]      domain_start_reg, domain_start_next;
    logic [SCALE_W-1:0]         domain_scale_reg, domain_scale_next;
    logic [TERM_W-1:0]          term_count_reg, term_count_next;
    logic signed [X_W:0]        diff_reg, diff_next;
    logic signed [63:0]         prod_reg, prod_next;
    logic                       t_neg_reg, t_neg_next;
    logic [TMAG_W-1:0]          t_mag_reg, t_mag_next;
    logic [JW-1:0]              j_reg, j_next;
    logic [NW-1:0]              n_reg, n_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]        m_tdata_reg, m_tdata_next;

    logic                  s_accept;
    logic                  kind;
    logic [IDX_W-1:0]      coef_index;
    logic signed [X_W-1:0] operand_value;
    logic                  ring_shift;
    step_ctl_t             step_ctl;
    logic [33:0]           q_clamped;
    logic signed [32:0]    t_val;
    logic signed [X_W-1:0] step_result;
    logic                  step_sat;
    logic signed [X_W-1:0] cell_word [MAX_TERMS];

    assign kind = s_tuser;
    assign coef_index = s_tdata[IDX_W-1:0];
    assign operand_value = $signed(s_tdata[IDX_W+X_W-1:IDX_W]);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TERMS; gi++) begin : g_ring
            logic                  cell_load;
            logic signed [X_W-1:0] cell_in;
            assign cell_load = s_accept && (kind == KIND_LOAD)
                               && (int'(coef_index) == gi);
            if (gi == 0) begin : g_wrap
                assign cell_in = cell_word[MAX_TERMS-1];
            end else begin : g_link
                assign cell_in = cell_word[gi-1];
            end
            cseu_cell u_cell (
                .aclk      (aclk),
                .load_en   (cell_load),
                .load_word (operand_value),
                .shift_en  (ring_shift),
                .shift_in  (cell_in),
                .word_out  (cell_word[gi])
            );
        end
    endgenerate

    cseu_step u_step (
        .aclk      (aclk),
        .ctl       (step_ctl),
        .t_neg     (t_neg_reg),
        .t_mag     (t_mag_reg),
        .coef      (cell_word[MAX_TERMS-1]),
        .result    (step_result),
        .saturated (step_sat)
    );

    always_comb begin
        if (prod_reg < 0) begin
            q_clamped = '0;
        end else if (prod_reg > Q_CLAMP_HI) begin
            q_clamped = Q_CLAMP_HI[33:0];
        end else begin
            q_clamped = prod_reg[33:0];
        end
        t_val = $signed({1'b0, q_clamped[33:2]}) - T_ONE;
    end

    always_comb begin
        state_next = state_reg;
        domain_start_next = domain_start_reg;
        domain_scale_next = domain_scale_reg;
        term_count_next = term_count_reg;
        diff_next = diff_reg;
        prod_next = diff_reg * $signed({1'b0, domain_scale_reg});
        t_neg_next = t_val[32];
        t_mag_next = t_val[32] ? TMAG_W'(-t_val) : TMAG_W'(t_val);
        j_next = j_reg;
        n_next = n_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next = m_tdata_reg;
        ring_shift = 1'b0;
        step_ctl = '0;

        if (cfg_we) begin
            unique case (cfg_index)
                REG_DOMAIN_START: domain_start_next = $signed(cfg_wdata);
                REG_DOMAIN_SCALE: domain_scale_next = cfg_wdata[SCALE_W-1:0];
                REG_TERM_COUNT:   term_count_next = cfg_wdata[TERM_W-1:0];
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (kind == KIND_EVAL)) begin
                    diff_next = (X_W+1)'(operand_value) - (X_W+1)'(domain_start_reg);
                    if (int'(term_count_reg) > MAX_TERMS) begin
                        n_next = NW'(MAX_TERMS);
                    end else begin
                        n_next = NW'(term_count_reg);
                    end
                    state_next = ST_MAP;
                end
            end
            ST_MAP: begin
                state_next = ST_TMAP;
            end
            ST_TMAP: begin
                step_ctl.clear = 1'b1;
                j_next = JW'(MAX_TERMS - 1);
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if ((j_reg != '0) && (int'(j_reg) >= int'(n_reg))) begin
                    ring_shift = 1'b1;
                    j_next = j_reg - 1'b1;
                end else begin
                    step_ctl.mul = 1'b1;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                step_ctl.acc = 1'b1;
                step_ctl.last_term = (j_reg == '0);
                step_ctl.empty = (n_reg == '0);
                ring_shift = 1'b1;
                if (j_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    j_next = j_reg - 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next = {7'd0, step_sat, step_result};
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            domain_start_reg <= RST_DOMAIN_START;
            domain_scale_reg <= RST_DOMAIN_SCALE;
            term_count_reg <= RST_TERM_COUNT;
            m_tvalid_reg <= 1'b0;
            j_reg <= '0;
            n_reg <= '0;
        end else begin
            state_reg <= state_next;
            domain_start_reg <= domain_start_next;
            domain_scale_reg <= domain_scale_next;
            term_count_reg <= term_count_next;
            m_tvalid_reg <= m_tvalid_next;
            j_reg <= j_next;
            n_reg <= n_next;
        end
    end

    always_ff @(posedge aclk) begin
        diff_reg <= diff_next;
        prod_reg <= prod_next;
        t_neg_reg <= t_neg_next;
        t_mag_reg <= t_mag_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

endmodule

@@ hw/rtl/cseu_checker.sv @@
module cseu_checker import cseu_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    a_reset_empties_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Output valid after reset.");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled output transaction changed.");

    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == KIND_EVAL) |=> !s_tready)
        else $error("Input accepted while an evaluation is in flight.");

    a_sat_clips: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |->
            (m_tdata[31:0] == 32'h7FFF_FFFF) || (m_tdata[31:0] == 32'h8000_0000))
        else $error("Saturated flag set on an unclipped value.");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_DATA_W-1:33] == '0))
        else $error("Output padding bits are not zero.");

endmodule

bind chebyshev_series_evaluator_unit cseu_checker u_cseu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
